/* src/dvrt_pkg.sv */
// Shared types and constants for the distance-vector route table.
// Used by every module of the block except dvrt_ram; depends on nothing.
package dvrt_pkg;

  // Field widths fixed by the item format
  localparam int NODE_W    = 6;
  localparam int DIST_W    = 8;
  localparam int TTL_W     = 7;
  localparam int ENTRY_W   = DIST_W + NODE_W;
  localparam int NODES_DEF = 64;
  localparam int CMDQ_DEPTH = 2;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Input item kinds (carried on in_tuser)
  typedef enum logic [1:0] {
    KIND_INSTALL = 2'd0,
    KIND_UPDATE  = 2'd1,
    KIND_FORWARD = 2'd2,
    KIND_ADVERT  = 2'd3
  } kind_t;

  // Result status codes (carried on out_tuser)
  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_FORWARDED = 3'd1,
    ST_EXPIRED   = 3'd2,
    ST_NOROUTE   = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // Classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_INSTALL = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_DELIVER = 3'd2,
    OP_NOROUTE = 3'd3,
    OP_FORWARD = 3'd4,
    OP_ADVERT  = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] dest;
    logic [NODE_W-1:0] nbr;
    logic [DIST_W-1:0] hop_dist;
    logic [TTL_W-1:0]  ttl;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] hop;
    logic [DIST_W-1:0] hop_dist;
    logic [TTL_W-1:0]  ttl;
    logic              last;
  } res_t;

endpackage

/* src/distance_vector_route_table.sv */
// Top level of the distance-vector route table.
// Depends on dvrt_pkg, dvrt_front, dvrt_fifo and dvrt_back.
//
// The block holds one route per destination node (valid mark, hop distance,
// next hop) in a NODES-deep RAM, with the valid marks in flip-flops cleared at
// reset. A front end classifies each input item and places the ones it keeps
// (out-of-table installs and updates are dropped) in a two-entry command
// queue; a back end carries commands out against the table. Install and route
// updates each pop the queue with a table read, then decide and write. A
// forward lookup gives one result. An advertise run walks the table one index
// per cycle, stopping at each valid entry to emit it (waiting while the output
// is stalled), up to the last valid entry; an empty table gives a single result.
// Results wait in an output register, so input keeps being taken into the
// queue while a result is stalled, until the queue is full. own_node_id lies
// at byte address 0.
module distance_vector_route_table import dvrt_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // dest_node[5:0] neighbor_node[11:6] distance[19:12] ttl[26:20]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // entry_node[5:0] next_hop[11:6] distance_out[19:12] ttl_out[26:20]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast,  // last
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [NODE_W-1:0] own_id_r;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  cmd_t              q_cmd;
  cmd_t              q_head;
  res_t              res;

  // Register file: own node id at index 0
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32 - NODE_W){1'b0}}, own_id_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      own_id_r <= cfg_pwdata[NODE_W-1:0];
    end
  end

  dvrt_front #(
    .NODES(NODES)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_kind  (in_tuser),
    .in_dest  (in_tdata[5:0]),
    .in_nbr   (in_tdata[11:6]),
    .in_dist  (in_tdata[19:12]),
    .in_ttl   (in_tdata[26:20]),
    .own_id   (own_id_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  dvrt_fifo u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  dvrt_back #(
    .NODES(NODES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  // Pack result fields
  assign out_tdata = {5'd0, res.ttl, res.hop_dist, res.hop, res.node};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

/* src/dvrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

/* src/dvrt_front.sv */
// Front end: accepts input items, classifies them and builds queue commands.
// Depends on dvrt_pkg.
module dvrt_front import dvrt_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_kind,
  input  logic [NODE_W-1:0] in_dest,
  input  logic [NODE_W-1:0] in_nbr,
  input  logic [DIST_W-1:0] in_dist,
  input  logic [TTL_W-1:0]  in_ttl,
  input  logic [NODE_W-1:0] own_id,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic in_table;
  logic keep;

  assign in_table  = int'(in_dest) < NODES;
  assign in_tready = !q_full;

  // Classify the item; out-of-table writes are dropped here
  always_comb begin
    q_cmd.dest     = in_dest;
    q_cmd.nbr      = in_nbr;
    q_cmd.hop_dist = in_dist;
    q_cmd.ttl      = in_ttl;
    q_cmd.op       = OP_INSTALL;
    keep           = 1'b1;
    case (kind_t'(in_kind))
      KIND_INSTALL: begin
        q_cmd.op = OP_INSTALL;
        keep     = in_table;
      end
      KIND_UPDATE: begin
        q_cmd.op       = OP_UPDATE;
        keep           = in_table;
        // saturate advertised distance plus one
        q_cmd.hop_dist = (in_dist == DIST_MAX) ? DIST_MAX : in_dist + DIST_W'(1);
      end
      KIND_FORWARD: begin
        if (in_dest == own_id) begin
          q_cmd.op = OP_DELIVER;
        end else if (!in_table) begin
          q_cmd.op = OP_NOROUTE;
        end else begin
          q_cmd.op = OP_FORWARD;
        end
      end
      KIND_ADVERT: begin
        q_cmd.op = OP_ADVERT;
      end
      default: begin
        q_cmd.op = OP_ADVERT;
      end
    endcase
  end

  assign q_push = in_tvalid && in_tready && keep;

endmodule

/* src/dvrt_fifo.sv */
// Short command queue between front end and back end.
// Depends on dvrt_pkg.
module dvrt_fifo import dvrt_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign head  = slot_r[rptr_r];

  // Advance pointers with explicit wrap
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

/* src/dvrt_back.sv */
// Back end: executes queued commands against the route table and drives
// the result register. Depends on dvrt_pkg and dvrt_ram.
module dvrt_back import dvrt_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_head,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int IDX_W = $clog2(NODES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [NODES-1:0]   valid_r, valid_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [NODE_W-1:0]  rd_hop;
  logic [DIST_W-1:0]  rd_dist;
  logic [IDX_W-1:0]   cmd_idx;
  logic               out_free;
  logic               last_entry;

  dvrt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODES)
  ) u_table (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  assign rd_hop     = ram_rdata[NODE_W-1:0];
  assign rd_dist    = ram_rdata[ENTRY_W-1:NODE_W];
  assign cmd_idx    = cmd_r.dest[IDX_W-1:0];
  assign out_free   = !out_valid_r || out_ready;
  // no valid entry above the current scan index
  assign last_entry = ~|((valid_r >> idx_r) >> 1);

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign ram_re    = q_pop || ((state_r == S_SCAN) && valid_r[idx_r]);
  assign ram_raddr = (state_r == S_IDLE) ? q_head.dest[IDX_W-1:0] : idx_r;
  assign ram_waddr = cmd_idx;
  assign ram_wdata = {cmd_r.hop_dist, cmd_r.nbr};

  // Sequence commands and the advertise walk
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    ram_we        = 1'b0;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r.op)
          OP_INSTALL: begin
            ram_we             = 1'b1;
            valid_nxt[cmd_idx] = 1'b1;
            state_nxt          = S_IDLE;
          end
          OP_UPDATE: begin
            if (!valid_r[cmd_idx] || rd_hop == cmd_r.nbr || cmd_r.hop_dist < rd_dist) begin
              ram_we             = 1'b1;
              valid_nxt[cmd_idx] = 1'b1;
            end
            state_nxt = S_IDLE;
          end
          OP_ADVERT: begin
            if (|valid_r) begin
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end else if (out_free) begin
              res_nxt       = '0;
              res_nxt.status = ST_EMPTY;
              res_nxt.last  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            // delivered, no route, forward
            if (out_free) begin
              res_nxt       = '0;
              res_nxt.node  = cmd_r.dest;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
              if (cmd_r.op == OP_DELIVER) begin
                res_nxt.status = ST_DELIVERED;
              end else if (cmd_r.op == OP_NOROUTE || !valid_r[cmd_idx]) begin
                res_nxt.status = ST_NOROUTE;
              end else if (cmd_r.ttl <= TTL_W'(1)) begin
                res_nxt.status = ST_EXPIRED;
              end else begin
                res_nxt.status = ST_FORWARDED;
                res_nxt.hop    = rd_hop;
                res_nxt.ttl    = cmd_r.ttl - TTL_W'(1);
              end
            end
          end
        endcase
      end
      S_SCAN: begin
        if (valid_r[idx_r]) begin
          state_nxt = S_EMIT;
        end else if (idx_r == IDX_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_nxt.status   = ST_ENTRY;
          res_nxt.node     = NODE_W'(idx_r);
          res_nxt.hop      = rd_hop;
          res_nxt.hop_dist = rd_dist;
          res_nxt.ttl      = '0;
          res_nxt.last     = last_entry;
          out_valid_nxt    = 1'b1;
          if (last_entry || idx_r == IDX_W'(NODES - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture popped command and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
